@@ rtl/mbt_pkg.sv @@
`default_nettype none
package mbt_pkg;

    localparam int MOD_W   = 31;
    localparam int OPD_W   = 63;
    localparam int TC_W    = 12;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int CNT_W   = 6;
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;

    localparam int DEF_TABLE_SIZE = 4096;

    localparam logic [MOD_W-1:0] RESET_MODULUS     = 31'd998244353;
    localparam logic [TC_W-1:0]  RESET_TABLE_COUNT = 12'd4095;

    typedef enum logic [1:0] {
        MODE_BUILD = 2'd0,
        MODE_COMB  = 2'd1,
        MODE_PERM  = 2'd2,
        MODE_MUL   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_UNBUILT = 2'd2
    } status_t;

    typedef enum logic {
        REG_MODULUS     = 1'b0,
        REG_TABLE_COUNT = 1'b1
    } reg_sel_t;

    typedef enum logic [2:0] {
        CMD_DIRECT,
        CMD_BUILD,
        CMD_MUL,
        CMD_COMB,
        CMD_PERM
    } cmd_op_t;

    typedef enum logic [4:0] {
        BK_IDLE,
        BK_FINISH,
        BK_B0,
        BK_B1,
        BK_BNEXT,
        BK_BDIV,
        BK_BRDINV,
        BK_BSTART,
        BK_BT,
        BK_BF,
        BK_BI,
        BK_MA,
        BK_MB,
        BK_QWAIT,
        BK_QF,
        BK_QD,
        BK_QB
    } bk_state_t;

    typedef struct packed {
        mode_t             mode;
        logic [OPD_W-1:0]  first_operand;
        logic [OPD_W-1:0]  second_operand;
    } in_item_t;

    typedef struct packed {
        logic [MOD_W-1:0]  value;
        status_t           status;
    } out_item_t;

    // Classified command handed from the front to the back.
    typedef struct packed {
        cmd_op_t           op;
        status_t           status;
        logic [OPD_W-1:0]  opa;
        logic [OPD_W-1:0]  opb;
    } cmd_t;

    typedef struct packed {
        logic              start;
        logic [MOD_W-1:0]  x;
        logic [OPD_W-1:0]  y;
        logic [CNT_W-1:0]  nbits;
    } mm_req_t;

    typedef struct packed {
        logic              done;
        logic [MOD_W-1:0]  r;
    } mm_rsp_t;

endpackage
`default_nettype wire

@@ rtl/modular_binomial_table_engine.sv @@
`default_nettype none
// Binomial, permutation and modular product engine over factorial tables.
// Items enter on in_valid/in_stall/in_item and results leave on
// out_valid/out_stall/out_item, one result for each item, in order.
// The modulus and table count are to be written over the APB port only
// while idle; the block does not enforce this. A build item (mode 0) fills
// index 0 and 1, then for each further index does a bit-serial division of
// the modulus by the index and three modular products, all through one
// shared double-and-add unit. A combination uses three 31-bit products, a
// permutation two, a multiply two 63-bit products, and an error result none.
// A two-entry command queue lets the front accept items while the back works;
// when it is full in_stall rises. A result waits in the output register while
// out_stall is high, and the back holds its next result until it is taken.
// Reset empties the queue, drops any result, restores the register defaults
// and marks the tables unbuilt; table contents are not cleared.
module modular_binomial_table_engine #(
    parameter int TABLE_SIZE = mbt_pkg::DEF_TABLE_SIZE
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire mbt_pkg::in_item_t           in_item,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output mbt_pkg::out_item_t               out_item,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mbt_pkg::PADDR_W-1:0] paddr,
    input  wire logic [mbt_pkg::PDATA_W-1:0] pwdata,
    output logic [mbt_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready
);
    import mbt_pkg::*;

    logic [MOD_W-1:0] modulus_reg, modulus_next;
    logic [TC_W-1:0]  table_count_reg, table_count_next;
    logic [MOD_W-1:0] eff_modulus;
    reg_sel_t         reg_sel;
    logic             wr_en;

    logic             q_push, q_pop, q_full, q_avail;
    cmd_t             front_cmd, head_cmd;

    assign pready  = 1'b1;
    assign reg_sel = reg_sel_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;

    // A modulus below two behaves as arithmetic modulo one.
    assign eff_modulus = (modulus_reg < MOD_W'(2)) ? MOD_W'(1) : modulus_reg;

    always_comb
    begin
        modulus_next     = modulus_reg;
        table_count_next = table_count_reg;
        prdata           = '0;
        case (reg_sel)
            REG_MODULUS:
            begin
                prdata = PDATA_W'(modulus_reg);
                if (wr_en)
                    modulus_next = pwdata[MOD_W-1:0];
            end
            REG_TABLE_COUNT:
            begin
                prdata = PDATA_W'(table_count_reg);
                if (wr_en)
                    table_count_next = pwdata[TC_W-1:0];
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg     <= RESET_MODULUS;
            table_count_reg <= RESET_TABLE_COUNT;
        end
        else
        begin
            modulus_reg     <= modulus_next;
            table_count_reg <= table_count_next;
        end
    end

    mbt_front #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .table_count (table_count_reg),
        .q_full      (q_full),
        .push        (q_push),
        .cmd         (front_cmd)
    );

    mbt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .head     (head_cmd),
        .full     (q_full),
        .avail    (q_avail)
    );

    mbt_back #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .modulus   (eff_modulus),
        .cmd       (head_cmd),
        .cmd_avail (q_avail),
        .cmd_pop   (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule
`default_nettype wire

@@ rtl/mbt_front.sv @@
`default_nettype none
module mbt_front #(
    parameter int TABLE_SIZE = mbt_pkg::DEF_TABLE_SIZE
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire mbt_pkg::in_item_t       in_item,
    input  wire logic [mbt_pkg::TC_W-1:0] table_count,
    input  wire logic                    q_full,
    output logic                         push,
    output mbt_pkg::cmd_t                cmd
);
    import mbt_pkg::*;

    localparam int IDXW = $clog2(TABLE_SIZE);

    logic            tables_valid_reg, tables_valid_next;
    logic [IDXW-1:0] built_limit_reg, built_limit_next;
    logic [IDXW-1:0] lim;
    logic            accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign push     = accept;

    always_comb
    begin
        if (32'(table_count) > TABLE_SIZE - 1)
            lim = IDXW'(TABLE_SIZE - 1);
        else
            lim = IDXW'(table_count);
    end

    // The front keeps its own view of the built tables so that queries queued
    // behind a build are classified against that build.
    always_comb
    begin
        tables_valid_next = tables_valid_reg;
        built_limit_next  = built_limit_reg;
        cmd.op     = CMD_DIRECT;
        cmd.status = ST_OK;
        cmd.opa    = in_item.first_operand;
        cmd.opb    = in_item.second_operand;
        case (in_item.mode)
            MODE_BUILD:
            begin
                cmd.op  = CMD_BUILD;
                cmd.opa = OPD_W'(lim);
                if (accept)
                begin
                    tables_valid_next = 1'b1;
                    built_limit_next  = lim;
                end
            end
            MODE_MUL:
            begin
                cmd.op = CMD_MUL;
            end
            MODE_COMB, MODE_PERM:
            begin
                if (!tables_valid_reg)
                    cmd.status = ST_UNBUILT;
                else if (in_item.first_operand > OPD_W'(built_limit_reg))
                    cmd.status = ST_RANGE;
                else if (in_item.first_operand < in_item.second_operand)
                    cmd.status = ST_OK;
                else if (in_item.mode == MODE_COMB)
                    cmd.op = CMD_COMB;
                else
                    cmd.op = CMD_PERM;
            end
            default:
            begin
                cmd.op = CMD_DIRECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tables_valid_reg <= 1'b0;
            built_limit_reg  <= '0;
        end
        else
        begin
            tables_valid_reg <= tables_valid_next;
            built_limit_reg  <= built_limit_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/mbt_queue.sv @@
`default_nettype none
module mbt_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire mbt_pkg::cmd_t  push_cmd,
    input  wire logic           pop,
    output mbt_pkg::cmd_t       head,
    output logic                full,
    output logic                avail
);
    import mbt_pkg::*;

    cmd_t                 entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]     count_reg, count_next;

    assign full  = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign avail = (count_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule
`default_nettype wire

@@ rtl/mbt_mulmod.sv @@
`default_nettype none
module mbt_mulmod (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire mbt_pkg::mm_req_t         req,
    input  wire logic [mbt_pkg::MOD_W-1:0] modulus,
    output mbt_pkg::mm_rsp_t              rsp
);
    import mbt_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [MOD_W-1:0] acc_reg;
    logic [MOD_W-1:0] x_reg;
    logic [OPD_W-1:0] y_reg;

    logic [MOD_W:0]   dbl, dbl_red, sum, sum_red, p_ext;

    // Double-and-add over the multiplier bits, most significant first.
    // The accumulator stays below the modulus, so each step needs at most
    // one subtraction after the doubling and one after the addition.
    always_comb
    begin
        p_ext   = {1'b0, modulus};
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= p_ext) ? dbl - p_ext : dbl;
        sum     = dbl_red + (y_reg[OPD_W-1] ? {1'b0, x_reg} : '0);
        sum_red = (sum >= p_ext) ? sum - p_ext : sum;
    end

    assign rsp.done = done_reg;
    assign rsp.r    = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.nbits;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg <= '0;
            x_reg   <= req.x;
            y_reg   <= req.y << (7'(OPD_W) - {1'b0, req.nbits});
        end
        else if (busy_reg)
        begin
            acc_reg <= sum_red[MOD_W-1:0];
            y_reg   <= {y_reg[OPD_W-2:0], 1'b0};
        end
    end

endmodule
`default_nettype wire

@@ rtl/mbt_back.sv @@
`default_nettype none
module mbt_back #(
    parameter int TABLE_SIZE = mbt_pkg::DEF_TABLE_SIZE
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [mbt_pkg::MOD_W-1:0] modulus,
    input  wire mbt_pkg::cmd_t            cmd,
    input  wire logic                     cmd_avail,
    output logic                          cmd_pop,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output mbt_pkg::out_item_t            out_item
);
    import mbt_pkg::*;

    localparam int IDXW = $clog2(TABLE_SIZE);
    localparam int CTRW = IDXW + 1;

    bk_state_t        state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [CTRW-1:0]  i_reg, i_next;
    logic [MOD_W-1:0] fact_prev_reg, fact_prev_next;
    logic [MOD_W-1:0] ifact_prev_reg, ifact_prev_next;
    logic [MOD_W-1:0] inv_i_reg, inv_i_next;
    logic [MOD_W-1:0] quo_reg, quo_next;
    logic [IDXW-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0] dcnt_reg, dcnt_next;
    logic [MOD_W-1:0] res_val_reg, res_val_next;
    status_t          res_st_reg, res_st_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_item_reg, out_item_next;

    logic [MOD_W-1:0] fact_mem  [TABLE_SIZE];
    logic [MOD_W-1:0] inv_mem   [TABLE_SIZE];
    logic [MOD_W-1:0] ifact_mem [TABLE_SIZE];
    logic [MOD_W-1:0] fact_rd_reg, inv_rd_reg, ifact_rd_reg;
    logic [IDXW-1:0]  fact_raddr, ifact_raddr;
    logic             mem_we;
    logic [MOD_W-1:0] fact_wd, inv_wd, ifact_wd;

    mm_req_t          mm_req;
    mm_rsp_t          mm_rsp;

    logic [MOD_W-1:0] one_mod;
    logic [IDXW-1:0]  lim;
    logic [IDXW:0]    trial;
    logic             trial_ge;

    mbt_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mm_req),
        .modulus (modulus),
        .rsp     (mm_rsp)
    );

    assign one_mod   = (modulus == MOD_W'(1)) ? '0 : MOD_W'(1);
    assign lim       = cmd_reg.opa[IDXW-1:0];
    assign trial     = {rem_reg, quo_reg[MOD_W-1]};
    assign trial_ge  = (trial >= i_reg);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Addresses are taken from the queue head while idle so that the
    // factorial read is registered and ready in BK_QWAIT, the state after the pop.
    always_comb
    begin
        if (state_reg == BK_IDLE)
        begin
            fact_raddr  = cmd.opa[IDXW-1:0];
            ifact_raddr = cmd.opa[IDXW-1:0] - cmd.opb[IDXW-1:0];
        end
        else
        begin
            fact_raddr = cmd_reg.opa[IDXW-1:0];
            if (state_reg == BK_QD || state_reg == BK_QB)
                ifact_raddr = cmd_reg.opb[IDXW-1:0];
            else
                ifact_raddr = cmd_reg.opa[IDXW-1:0] - cmd_reg.opb[IDXW-1:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        i_next          = i_reg;
        fact_prev_next  = fact_prev_reg;
        ifact_prev_next = ifact_prev_reg;
        inv_i_next      = inv_i_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        dcnt_next       = dcnt_reg;
        res_val_next    = res_val_reg;
        res_st_next     = res_st_reg;
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        cmd_pop         = 1'b0;
        mem_we          = 1'b0;
        fact_wd         = one_mod;
        inv_wd          = one_mod;
        ifact_wd        = one_mod;
        mm_req.start    = 1'b0;
        mm_req.x        = one_mod;
        mm_req.y        = '0;
        mm_req.nbits    = CNT_W'(MOD_W);

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_avail)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                    i_next   = '0;
                    case (cmd.op)
                        CMD_DIRECT:
                        begin
                            res_val_next = '0;
                            res_st_next  = cmd.status;
                            state_next   = BK_FINISH;
                        end
                        CMD_BUILD:
                        begin
                            state_next = BK_B0;
                        end
                        CMD_MUL:
                        begin
                            mm_req.start = 1'b1;
                            mm_req.x     = one_mod;
                            mm_req.y     = cmd.opa;
                            mm_req.nbits = CNT_W'(OPD_W);
                            state_next   = BK_MA;
                        end
                        CMD_COMB, CMD_PERM:
                        begin
                            state_next = BK_QWAIT;
                        end
                        default:
                        begin
                            state_next = BK_IDLE;
                        end
                    endcase
                end
            end
            BK_B0:
            begin
                mem_we          = 1'b1;
                inv_wd          = '0;
                fact_prev_next  = one_mod;
                ifact_prev_next = one_mod;
                i_next          = CTRW'(1);
                state_next      = BK_B1;
            end
            BK_B1:
            begin
                res_val_next = '0;
                res_st_next  = ST_OK;
                if (lim == '0)
                    state_next = BK_FINISH;
                else
                begin
                    mem_we     = 1'b1;
                    i_next     = CTRW'(2);
                    state_next = BK_BNEXT;
                end
            end
            BK_BNEXT:
            begin
                if (i_reg > {1'b0, lim})
                    state_next = BK_FINISH;
                else
                begin
                    quo_next   = modulus;
                    rem_next   = '0;
                    dcnt_next  = CNT_W'(MOD_W);
                    state_next = BK_BDIV;
                end
            end
            BK_BDIV:
            begin
                // Restoring division of the modulus by the index, one bit a cycle.
                rem_next  = trial_ge ? IDXW'(trial - i_reg) : IDXW'(trial);
                quo_next  = {quo_reg[MOD_W-2:0], trial_ge};
                dcnt_next = dcnt_reg - 1'b1;
                if (dcnt_reg == CNT_W'(1))
                    state_next = BK_BRDINV;
            end
            BK_BRDINV:
            begin
                state_next = BK_BSTART;
            end
            BK_BSTART:
            begin
                mm_req.start = 1'b1;
                mm_req.x     = inv_rd_reg;
                mm_req.y     = OPD_W'(quo_reg);
                mm_req.nbits = CNT_W'(MOD_W);
                state_next   = BK_BT;
            end
            BK_BT:
            begin
                if (mm_rsp.done)
                begin
                    inv_i_next   = (mm_rsp.r == '0) ? '0 : modulus - mm_rsp.r;
                    mm_req.start = 1'b1;
                    mm_req.x     = fact_prev_reg;
                    mm_req.y     = OPD_W'(i_reg);
                    mm_req.nbits = CNT_W'(CTRW);
                    state_next   = BK_BF;
                end
            end
            BK_BF:
            begin
                if (mm_rsp.done)
                begin
                    fact_prev_next = mm_rsp.r;
                    mm_req.start   = 1'b1;
                    mm_req.x       = ifact_prev_reg;
                    mm_req.y       = OPD_W'(inv_i_reg);
                    mm_req.nbits   = CNT_W'(MOD_W);
                    state_next     = BK_BI;
                end
            end
            BK_BI:
            begin
                if (mm_rsp.done)
                begin
                    mem_we          = 1'b1;
                    fact_wd         = fact_prev_reg;
                    inv_wd          = inv_i_reg;
                    ifact_wd        = mm_rsp.r;
                    ifact_prev_next = mm_rsp.r;
                    i_next          = i_reg + 1'b1;
                    state_next      = BK_BNEXT;
                end
            end
            BK_MA:
            begin
                if (mm_rsp.done)
                begin
                    mm_req.start = 1'b1;
                    mm_req.x     = mm_rsp.r;
                    mm_req.y     = cmd_reg.opb;
                    mm_req.nbits = CNT_W'(OPD_W);
                    state_next   = BK_MB;
                end
            end
            BK_MB:
            begin
                if (mm_rsp.done)
                begin
                    res_val_next = mm_rsp.r;
                    res_st_next  = ST_OK;
                    state_next   = BK_FINISH;
                end
            end
            BK_QWAIT:
            begin
                // Table entries may predate a modulus change, so reduce first.
                mm_req.start = 1'b1;
                mm_req.x     = one_mod;
                mm_req.y     = OPD_W'(fact_rd_reg);
                mm_req.nbits = CNT_W'(MOD_W);
                state_next   = BK_QF;
            end
            BK_QF:
            begin
                if (mm_rsp.done)
                begin
                    mm_req.start = 1'b1;
                    mm_req.x     = mm_rsp.r;
                    mm_req.y     = OPD_W'(ifact_rd_reg);
                    mm_req.nbits = CNT_W'(MOD_W);
                    state_next   = BK_QD;
                end
            end
            BK_QD:
            begin
                if (mm_rsp.done)
                begin
                    if (cmd_reg.op == CMD_PERM)
                    begin
                        res_val_next = mm_rsp.r;
                        res_st_next  = ST_OK;
                        state_next   = BK_FINISH;
                    end
                    else
                    begin
                        mm_req.start = 1'b1;
                        mm_req.x     = mm_rsp.r;
                        mm_req.y     = OPD_W'(ifact_rd_reg);
                        mm_req.nbits = CNT_W'(MOD_W);
                        state_next   = BK_QB;
                    end
                end
            end
            BK_QB:
            begin
                if (mm_rsp.done)
                begin
                    res_val_next = mm_rsp.r;
                    res_st_next  = ST_OK;
                    state_next   = BK_FINISH;
                end
            end
            BK_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next       = 1'b1;
                    out_item_next.value  = res_val_reg;
                    out_item_next.status = res_st_reg;
                    state_next           = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        i_reg          <= i_next;
        fact_prev_reg  <= fact_prev_next;
        ifact_prev_reg <= ifact_prev_next;
        inv_i_reg      <= inv_i_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        dcnt_reg       <= dcnt_next;
        res_val_reg    <= res_val_next;
        res_st_reg     <= res_st_next;
        out_item_reg   <= out_item_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            fact_mem[i_reg[IDXW-1:0]]  <= fact_wd;
            inv_mem[i_reg[IDXW-1:0]]   <= inv_wd;
            ifact_mem[i_reg[IDXW-1:0]] <= ifact_wd;
        end
        fact_rd_reg  <= fact_mem[fact_raddr];
        inv_rd_reg   <= inv_mem[rem_reg];
        ifact_rd_reg <= ifact_mem[ifact_raddr];
    end

    a_mm_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        mm_rsp.done |-> (state_reg == BK_BT || state_reg == BK_BF || state_reg == BK_BI ||
                         state_reg == BK_MA || state_reg == BK_MB || state_reg == BK_QF ||
                         state_reg == BK_QD || state_reg == BK_QB))
        else $error("modular product finished with no step waiting for it");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.status != ST_OK) |-> (out_item_reg.value == '0))
        else $error("error result carries a nonzero value");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (state_reg == BK_IDLE && cmd_avail))
        else $error("command taken from the queue while busy or empty");

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mbt_pkg::*;

    localparam int IDX_MAX = 4095;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    in_item_t            in_item = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    out_item_t           out_item;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    modular_binomial_table_engine DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // Predictor state: our own copy of the tables and registers.
    logic [MOD_W-1:0]    fact_tab [0:IDX_MAX];
    logic [MOD_W-1:0]    inv_tab [0:IDX_MAX];
    logic [MOD_W-1:0]    ifact_tab [0:IDX_MAX];
    int unsigned         built_lim = 0;
    bit                  built = 1'b0;
    logic [MOD_W-1:0]    cur_mod = RESET_MODULUS;
    logic [TC_W-1:0]     cur_count = RESET_TABLE_COUNT;

    in_item_t            pending_items[$];
    out_item_t           expected_results[$];
    int                  errors = 0;
    int                  items_sent = 0;
    int                  results_checked = 0;
    int                  builds_sent = 0;
    bit                  gaps_on = 1'b1;

    function automatic longint unsigned eff_mod();
        return (cur_mod < 2) ? 64'd1 : 64'(cur_mod);
    endfunction

    function automatic longint unsigned mulmod(longint unsigned a, longint unsigned b,
                                               longint unsigned p);
        return ((a % p) * (b % p)) % p;
    endfunction

    task automatic build_tables();
        longint unsigned p;
        longint unsigned t;
        int unsigned lim;
        p = eff_mod();
        lim = cur_count;
        fact_tab[0] = 1 % p;
        inv_tab[0] = 0;
        ifact_tab[0] = 1 % p;
        if (lim >= 1)
        begin
            fact_tab[1] = 1 % p;
            inv_tab[1] = 1 % p;
            ifact_tab[1] = 1 % p;
        end
        for (int unsigned i = 2; i <= lim; i++)
        begin
            t = mulmod(inv_tab[p % i], p / i, p);
            fact_tab[i] = mulmod(fact_tab[i-1], i, p);
            inv_tab[i] = (p - t) % p;
            ifact_tab[i] = mulmod(ifact_tab[i-1], inv_tab[i], p);
        end
        built_lim = lim;
        built = 1'b1;
    endtask

    task automatic predict_result(in_item_t it);
        out_item_t r;
        longint unsigned p;
        longint unsigned a;
        longint unsigned b;
        longint unsigned v;
        p = eff_mod();
        a = 64'(it.first_operand);
        b = 64'(it.second_operand);
        r.value = '0;
        r.status = ST_OK;
        if (it.mode == MODE_BUILD)
            build_tables();
        else if (it.mode == MODE_MUL)
            r.value = mulmod(a, b, p);
        else if (!built)
            r.status = ST_UNBUILT;
        else if (a > built_lim)
            r.status = ST_RANGE;
        else if (a >= b)
        begin
            v = mulmod(fact_tab[a], ifact_tab[a-b], p);
            if (it.mode == MODE_COMB)
                v = mulmod(v, ifact_tab[b], p);
            r.value = v;
        end
        expected_results.push_back(r);
    endtask

    // Sender: one item at a time from the pending queue, with a random gap after each while gaps_on is set.
    int unsigned send_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_result(in_item);
                items_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    in_item <= pending_items.pop_front();
                    in_valid <= 1'b1;
                    send_gap <= gaps_on ? $urandom_range(0, 6) : 0;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver and checker. One long hold-off lets the block fill up.
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        int unsigned next_stall;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            next_stall = stall_left;
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result value=%0d status=%0d", $time,
                             out_item.value, out_item.status);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.value !== out_item.value || want.status !== out_item.status)
                    begin
                        $display("%0t: mismatch expected value=%0d status=%0d, actual value=%0d status=%0d",
                                 $time, want.value, want.status, out_item.value,
                                 out_item.status);
                        errors++;
                    end
                end
                results_checked++;
                next_stall = gaps_on ? $urandom_range(0, 6) : 0;
                if (!hold_done && results_checked == 120)
                begin
                    hold_done = 1'b1;
                    hold_left <= 1500;
                end
            end
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (next_stall != 0)
            begin
                stall_left <= next_stall - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left <= 0;
                out_stall <= 1'b0;
            end
        end
    end

    task automatic reg_write(reg_sel_t sel, logic [PDATA_W-1:0] data);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= PADDR_W'(sel) << 2;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (sel == REG_MODULUS)
            cur_mod = data[MOD_W-1:0];
        else
            cur_count = data[TC_W-1:0];
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic push_item(mode_t m, logic [OPD_W-1:0] a, logic [OPD_W-1:0] b);
        in_item_t it;
        it.mode = m;
        it.first_operand = a;
        it.second_operand = b;
        if (m == MODE_BUILD)
            builds_sent++;
        pending_items.push_back(it);
    endtask

    function automatic logic [OPD_W-1:0] rand_wide();
        return OPD_W'({$urandom, $urandom});
    endfunction

    // Mostly in-range queries with random operands, some multiplies and
    // out-of-range indexes, and, when allowed, a rare rebuild.
    task automatic push_random(int count, bit allow_build);
        int unsigned sel;
        logic [OPD_W-1:0] n;
        logic [OPD_W-1:0] k;
        for (int j = 0; j < count; j++)
        begin
            sel = $urandom_range(0, 99);
            if (allow_build && sel < 2)
                push_item(MODE_BUILD, rand_wide(), rand_wide());
            else if (sel < 20)
                push_item(MODE_MUL, rand_wide(), rand_wide());
            else
            begin
                case ($urandom_range(0, 9))
                    0: n = rand_wide();
                    1: n = built_lim;
                    2: n = built_lim + $urandom_range(1, 3);
                    default: n = $urandom_range(0, built_lim);
                endcase
                case ($urandom_range(0, 9))
                    0: k = rand_wide();
                    1: k = n + $urandom_range(1, 5);
                    2: k = n;
                    3: k = 0;
                    default: k = (n > IDX_MAX) ? rand_wide() : $urandom_range(0, 32'(n));
                endcase
                push_item(sel < 60 ? MODE_COMB : MODE_PERM, n, k);
            end
        end
    endtask

    typedef struct {
        logic [PDATA_W-1:0] modv;
        logic [PDATA_W-1:0] cnt;
    } setting_t;

    initial
    begin
        setting_t plan[$];
        logic [OPD_W-1:0] all_ones;
        all_ones = '1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Queries before any build, multiplies at the operand extremes.
        push_item(MODE_COMB, 5, 2);
        push_item(MODE_PERM, 0, 0);
        push_item(MODE_MUL, all_ones, all_ones);
        push_item(MODE_MUL, 0, all_ones);
        push_item(MODE_MUL, all_ones, 1);
        wait_idle();

        // Full-size table at the default modulus.
        reg_write(REG_MODULUS, 998244353);
        reg_write(REG_TABLE_COUNT, IDX_MAX);
        push_item(MODE_BUILD, all_ones, all_ones);
        push_item(MODE_COMB, IDX_MAX, 0);
        push_item(MODE_COMB, IDX_MAX, IDX_MAX);
        push_item(MODE_COMB, IDX_MAX, 1234);
        push_item(MODE_PERM, IDX_MAX, 2047);
        push_item(MODE_PERM, IDX_MAX + 1, 0);
        push_item(MODE_COMB, all_ones, 0);
        push_item(MODE_COMB, 10, 11);
        push_item(MODE_PERM, 3, all_ones);
        push_item(MODE_COMB, 0, 0);
        push_item(MODE_PERM, 1, 1);
        push_item(MODE_MUL, 998244353, 5);
        wait_idle();

        plan.push_back('{2, 1});
        plan.push_back('{3, 0});
        plan.push_back('{0, 5});
        plan.push_back('{1, 7});
        plan.push_back('{32'h7FFF_FFFF, 40});
        plan.push_back('{998244353, 200});
        plan.push_back('{12, 30});
        plan.push_back('{7, 30});
        plan.push_back('{1000000007, 150});
        plan.push_back('{65537, 90});
        plan.push_back('{13, 20});
        foreach (plan[s])
        begin
            gaps_on = (s % 4) != 2;
            reg_write(REG_MODULUS, plan[s].modv);
            reg_write(REG_TABLE_COUNT, plan[s].cnt);
            push_item(MODE_BUILD, rand_wide(), rand_wide());
            push_random(100, 1'b1);
            wait_idle();
            // Change the modulus over the existing tables without rebuilding.
            reg_write(REG_MODULUS, $urandom_range(2, 32'h7FFF_FFFF));
            push_random(40, 1'b0);
            wait_idle();
        end

        repeat (200) @(posedge clk);
        $display("Sent %0d items (%0d table builds) over %0d modulus/count settings,",
                 items_sent, builds_sent, plan.size() + 1);
        $display("checked %0d results including unbuilt, range and n<m cases.",
                 results_checked);
        if (errors == 0 && expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #60ms;
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/mbt_pkg.sv
rtl/mbt_front.sv
rtl/mbt_queue.sv
rtl/mbt_mulmod.sv
rtl/mbt_back.sv
rtl/modular_binomial_table_engine.sv
test/tb_top.sv
